>>> sv/alls_pkg.sv
// ----------------------------------------------------------------------------
// alls_pkg
// shared types and constants of the adaptive light level slicer
// ----------------------------------------------------------------------------
package alls_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned AccW      = SampleW + FracW;  // Q10.16
  localparam int unsigned LowW      = 20;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned ContrastW = 10;
  localparam int unsigned LimitW    = 20;

  localparam int unsigned InDataW   = 32;  // sample + elapsed, padded to bytes
  localparam int unsigned OutDataW  = 24;  // level_high + timed_out + low_time
  localparam int unsigned AddrW     = 4;
  localparam int unsigned RegDataW  = 32;

  localparam logic [ShiftW-1:0]    EaseShiftReset    = ShiftW'(10);
  localparam logic [ContrastW-1:0] ContrastMinReset  = ContrastW'(50);
  localparam logic [LimitW-1:0]    TimeoutLimitReset = LimitW'(1000);

  localparam logic [ShiftW-1:0]    ShiftMin = ShiftW'(1);
  localparam logic [ShiftW-1:0]    ShiftMax = ShiftW'(16);

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_EASE_SHIFT    = 2'd0,
    REG_CONTRAST_MIN  = 2'd1,
    REG_TIMEOUT_LIMIT = 2'd2
  } alls_reg_e;

  typedef struct packed {
    logic [ShiftW-1:0]    ease_shift;
    logic [ContrastW-1:0] contrast_min;
    logic [LimitW-1:0]    timeout_limit;
  } alls_cfg_t;

  typedef struct packed {
    logic [LowW-1:0] low_time;
    logic            timed_out;
    logic            level_high;
  } alls_res_t;

endpackage

>>> sv/alls_cfg_regs.sv
// ----------------------------------------------------------------------------
// alls_cfg_regs
// apb register file holding the slicer settings
// ----------------------------------------------------------------------------
module alls_cfg_regs import alls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [RegDataW-1:0] pwdata,
  output logic [RegDataW-1:0] prdata,
  output logic                pready,
  output alls_cfg_t           cfg_o
);

  alls_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  alls_reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = alls_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_EASE_SHIFT:    cfg_d.ease_shift    = pwdata[ShiftW-1:0];
        REG_CONTRAST_MIN:  cfg_d.contrast_min  = pwdata[ContrastW-1:0];
        REG_TIMEOUT_LIMIT: cfg_d.timeout_limit = pwdata[LimitW-1:0];
        default:           cfg_d = cfg_q;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EASE_SHIFT:    prdata = RegDataW'(cfg_q.ease_shift);
      REG_CONTRAST_MIN:  prdata = RegDataW'(cfg_q.contrast_min);
      REG_TIMEOUT_LIMIT: prdata = RegDataW'(cfg_q.timeout_limit);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ease_shift    <= EaseShiftReset;
      cfg_q.contrast_min  <= ContrastMinReset;
      cfg_q.timeout_limit <= TimeoutLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/alls_core.sv
// ----------------------------------------------------------------------------
// alls_core
// average and envelope state with the level and low time decision
// ----------------------------------------------------------------------------
module alls_core import alls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [ElapsedW-1:0] elapsed_i,
  input  alls_cfg_t           cfg_i,
  output alls_res_t           res_o
);

  logic [AccW-1:0] avg_q, avg_d;
  logic [AccW-1:0] env_min_q, env_min_d;
  logic [AccW-1:0] env_max_q, env_max_d;
  logic [LowW-1:0] low_q, low_d;

  logic [ShiftW-1:0]      k;
  logic [AccW-1:0]        s_fix;
  logic [AccW-1:0]        min_snap, max_snap;
  logic signed [AccW:0]   span;
  logic signed [AccW+1:0] mid;
  logic signed [AccW:0]   contrast_fix;
  logic [LowW:0]          low_sum;
  logic                   high;

  // x + floor((t - x) / 2^k), stays between x and t
  function automatic logic [AccW-1:0] ease(input logic [AccW-1:0] x,
                                           input logic [AccW-1:0] t,
                                           input logic [ShiftW-1:0] sh);
    logic signed [AccW:0] d;
    logic signed [AccW:0] q;
    logic signed [AccW:0] r;
    d = $signed({1'b0, t}) - $signed({1'b0, x});
    q = d >>> sh;
    r = $signed({1'b0, x}) + q;
    return r[AccW-1:0];
  endfunction

  always_comb begin
    k = cfg_i.ease_shift;
    if (k < ShiftMin) k = ShiftMin;
    if (k > ShiftMax) k = ShiftMax;
  end

  assign s_fix    = {sample_i, FracW'(0)};
  assign avg_d    = ease(avg_q, s_fix, k);
  assign max_snap = (s_fix > env_max_q) ? s_fix : env_max_q;
  assign min_snap = (s_fix < env_min_q) ? s_fix : env_min_q;
  assign env_min_d = ease(min_snap, avg_d, k);
  assign env_max_d = ease(max_snap, avg_d, k);

  assign span         = $signed({1'b0, env_max_d}) - $signed({1'b0, env_min_d});
  assign mid          = $signed({2'b00, env_min_d}) + (AccW+2)'(span >>> 1);
  assign contrast_fix = $signed({1'b0, cfg_i.contrast_min, FracW'(0)});

  // forced high when the envelopes sit closer than the contrast limit
  assign high = ($signed({2'b00, s_fix}) > mid) || (span < contrast_fix);

  assign low_sum = {1'b0, low_q} + (LowW+1)'(elapsed_i);

  always_comb begin
    if (high) begin
      low_d = '0;
    end else if (low_sum[LowW]) begin
      low_d = '1;  // saturate
    end else begin
      low_d = low_sum[LowW-1:0];
    end
  end

  assign res_o.level_high = high;
  assign res_o.low_time   = low_d;
  assign res_o.timed_out  = low_d > cfg_i.timeout_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q     <= '0;
      env_min_q <= '1;
      env_max_q <= '0;
      low_q     <= '0;
    end else if (step_i) begin
      avg_q     <= avg_d;
      env_min_q <= env_min_d;
      env_max_q <= env_max_d;
      low_q     <= low_d;
    end
  end

endmodule

>>> sv/adaptive_light_level_slicer.sv
// ----------------------------------------------------------------------------
// adaptive_light_level_slicer
// light level slicer with running average, easing envelopes and low timer
// ----------------------------------------------------------------------------
// result path: an accepted item is held in the input register, passes the core
//   logic and is held in the result register until the output takes it
// throughput: 1 item per cycle while not stalled, one core update per item
// reset: average and max envelope clear, min envelope all ones, low time
//   clears, settings return to shift 10, contrast 50, timeout 1000
module adaptive_light_level_slicer import alls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [9:0] sample, [25:10] elapsed
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] level_high, [1] timed_out,
                                              // [21:2] low_time
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [RegDataW-1:0] pwdata,
  output logic [RegDataW-1:0] prdata,
  output logic                pready
);

  alls_cfg_t cfg;
  alls_res_t res;

  // input register
  logic                in_valid_q, in_valid_d;
  logic [SampleW-1:0]  sample_q;
  logic [ElapsedW-1:0] elapsed_q;

  // result register
  logic                out_valid_q, out_valid_d;
  alls_res_t           out_q;

  logic in_accept;
  logic advance;   // item in the input register moves to the result register

  // the result register frees when empty or when taken this cycle
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q  <= s_axis_tdata[SampleW-1:0];
      elapsed_q <= s_axis_tdata[SampleW+ElapsedW-1:SampleW];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  alls_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // state advances exactly once per item, together with the result register
  alls_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .sample_i  (sample_q),
    .elapsed_i (elapsed_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  // a full pipeline with a stalled output takes no new item
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline is full and stalled");

  // a high level always clears the low timer
  a_high_clears_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[21:2] == '0))
    else $error("low time nonzero while level is high");

  // a timeout needs some accumulated low time
  a_timeout_needs_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[21:2] != '0))
    else $error("timeout flagged with zero low time");

endmodule
